/* hdl/slru_pkg.sv */
// Shared types, constants and helper functions of the sharded LRU replacer.
// Used by the link memory, the remainder unit and the top level.
`default_nettype none

package slru_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int MAX_SHARDS = 8;

  // Widths of the stream and configuration fields.
  localparam int FID_W       = 6;
  localparam int OP_W        = 2;
  localparam int CFG_W       = 4;
  localparam int CNT_OUT_W   = 7;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;
  localparam int HAND_W      = 64;

  // Internal widths derived from the build sizes.
  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int SHARD_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int NUM_W   = $clog2(MAX_SHARDS + 1);
  localparam int STEP_W  = $clog2(FID_W);
  localparam int TRIAL_W = FID_W + NUM_W;

  typedef enum logic [OP_W-1:0] {
    OP_VICTIM = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2,
    OP_SIZE   = 2'd3
  } op_t;

  typedef logic [FRAME_W-1:0] frame_t;

  // Request to the link memory: one registered read of both link words,
  // and one write into each of the two link arrays.
  typedef struct packed {
    logic   rd_en;
    frame_t rd_addr;
    logic   newer_wr_en;
    frame_t newer_wr_addr;
    frame_t newer_wr_data;
    logic   older_wr_en;
    frame_t older_wr_addr;
    frame_t older_wr_data;
  } slru_link_req_t;

  typedef struct packed {
    frame_t newer;
    frame_t older;
  } slru_link_rsp_t;

  // Clamp the programmed shard count to the range that is built.
  function automatic logic [NUM_W-1:0] live_shards(input logic [CFG_W-1:0] value);
    logic [NUM_W-1:0] result;
    if (value == '0) begin
      result = NUM_W'(1);
    end else if (int'(value) > MAX_SHARDS) begin
      result = NUM_W'(MAX_SHARDS);
    end else begin
      result = NUM_W'(value);
    end
    return result;
  endfunction

endpackage

`default_nettype wire

/* hdl/slru_link_mem.sv */
// Newer and older link arrays of the per-shard LRU lists.
// Single write port per array, one registered read of both; uses slru_pkg.
`default_nettype none

module slru_link_mem
  import slru_pkg::*;
(
  input  wire logic           clk,
  input  wire slru_link_req_t req,
  output slru_link_rsp_t      rsp
);

  frame_t newer_mem [MAX_FRAMES];
  frame_t older_mem [MAX_FRAMES];
  frame_t newer_q_r;
  frame_t older_q_r;

  always_ff @(posedge clk) begin
    if (req.newer_wr_en) begin
      newer_mem[req.newer_wr_addr] <= req.newer_wr_data;
    end
    if (req.older_wr_en) begin
      older_mem[req.older_wr_addr] <= req.older_wr_data;
    end
    if (req.rd_en) begin
      newer_q_r <= newer_mem[req.rd_addr];
      older_q_r <= older_mem[req.rd_addr];
    end
  end

  assign rsp.newer = newer_q_r;
  assign rsp.older = older_q_r;

endmodule

`default_nettype wire

/* hdl/slru_mod_unit.sv */
// Restoring remainder unit: frame id modulo the live shard count,
// one shared compare and subtract per cycle; uses slru_pkg.
`default_nettype none

module slru_mod_unit
  import slru_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [FID_W-1:0]   dividend,
  input  wire logic [NUM_W-1:0]   divisor,
  output logic                    done,
  output logic [SHARD_W-1:0]      remainder
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [FID_W-1:0]  rem_r;
  logic [NUM_W-1:0]  div_r;

  logic [TRIAL_W-1:0] trial;
  logic               fits;
  logic [FID_W-1:0]   rem_sub;

  // Try the divisor shifted left by the current step; keep the difference if it fits.
  assign trial   = TRIAL_W'(div_r) << step_r;
  assign fits    = TRIAL_W'(rem_r) >= trial;
  assign rem_sub = rem_r - FID_W'(trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      div_r  <= divisor;
      step_r <= STEP_W'(FID_W - 1);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_sub;
      end
      if (step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && step_r == '0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done      = done_r;
  assign remainder = SHARD_W'(rem_r);

endmodule

`default_nettype wire

/* hdl/sharded_lru_replacer_unit.sv */
// Sharded LRU replacer: sequencer, list heads, occupancy and tracking state.
// Instantiates slru_mod_unit and slru_link_mem; uses slru_pkg.
//
// Usage: requests arrive on the in_ stream, one transfer per request, with the
// operation code in in_tuser and the frame id in in_tdata. Each request gives
// exactly one result transfer on the out_ stream. The cfg_ channel writes the
// shard count; a write flushes all tracking but keeps the victim hand, and is
// taken only while the sequencer is idle (it wins over a request offered in
// the same cycle).
// Path from accepted request to result: a size query goes straight to the done
// state; pin and unpin wait for the 6-step remainder unit mapping a frame id to
// its shard; victim scans from the hand shard, passing over each empty shard, and
// visits all live shards when every shard is empty. Unlinking a frame from a shard
// of more than one adds the registered link memory read. One request is in flight
// at a time; a new request is taken only once the last one is through.
// in_tready is low while a request is in work.
// The result sits in an output register; a stalled receiver only holds the
// sequencer once the next result is ready. Reset sets the shard count to one,
// empties all shards and clears the hand; no clearing pass is needed.
`default_nettype none

module sharded_lru_replacer_unit
  import slru_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: [5:0] fid, [7:6] zero
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [1:0] op
  input  wire logic [OP_W-1:0]       in_tuser,
  // out_tdata: [0] found, [6:1] victim_frame, [13:7] tracked_count,
  // [14] bad_frame, [15] zero
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_APPLY,
    ST_UNLINK,
    ST_DONE
  } state_t;

  typedef logic [SHARD_W-1:0] shard_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Control state
  state_t                 state_r, state_nxt;
  logic [NUM_W-1:0]       n_r, n_nxt;
  logic [MAX_FRAMES-1:0]  tracked_r, tracked_nxt;
  cnt_t                   occ_r [MAX_SHARDS];
  cnt_t                   occ_nxt [MAX_SHARDS];
  cnt_t                   total_r, total_nxt;
  logic [HAND_W-1:0]      hand_r, hand_nxt;
  shard_t                 res_r [MAX_SHARDS];
  shard_t                 res_nxt [MAX_SHARDS];
  logic                   out_valid_r, out_valid_nxt;

  // Payload state
  frame_t                 newest_r [MAX_SHARDS];
  frame_t                 newest_nxt [MAX_SHARDS];
  frame_t                 oldest_r [MAX_SHARDS];
  frame_t                 oldest_nxt [MAX_SHARDS];
  op_t                    op_r, op_nxt;
  frame_t                 frame_r, frame_nxt;
  shard_t                 shard_r, shard_nxt;
  shard_t                 scan_cnt_r, scan_cnt_nxt;
  logic                   found_r, found_nxt;
  logic                   bad_r, bad_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic                   mod_start;
  logic                   mod_done;
  shard_t                 mod_rem;
  slru_link_req_t         link_req;
  slru_link_rsp_t         link_rsp;

  logic [FID_W-1:0]       in_fid;
  op_t                    in_op;
  logic [NUM_W-1:0]       scan_inc;
  logic                   hand_wrap;
  frame_t                 nw;
  frame_t                 od;
  frame_t                 head;

  assign in_fid    = in_tdata[FID_W-1:0];
  assign in_op     = op_t'(in_tuser);
  assign scan_inc  = NUM_W'(shard_r) + NUM_W'(1);
  assign hand_wrap = (hand_r == '1);
  assign nw        = link_rsp.newer;
  assign od        = link_rsp.older;
  assign head      = newest_r[shard_r];

  assign cfg_ready  = (state_r == ST_IDLE);
  assign in_tready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  slru_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_fid),
    .divisor   (n_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  slru_link_mem u_links (
    .clk (clk),
    .req (link_req),
    .rsp (link_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    tracked_nxt   = tracked_r;
    occ_nxt       = occ_r;
    total_nxt     = total_r;
    hand_nxt      = hand_r;
    res_nxt       = res_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    op_nxt        = op_r;
    frame_nxt     = frame_r;
    shard_nxt     = shard_r;
    scan_cnt_nxt  = scan_cnt_r;
    found_nxt     = found_r;
    bad_nxt       = bad_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mod_start     = 1'b0;
    link_req      = '0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          n_nxt       = live_shards(cfg_data);
          tracked_nxt = '0;
          total_nxt   = '0;
          for (int k = 0; k < MAX_SHARDS; k++) begin
            occ_nxt[k] = '0;
          end
        end else if (in_tvalid) begin
          op_nxt    = in_op;
          found_nxt = 1'b0;
          bad_nxt   = 1'b0;
          unique case (in_op)
            OP_VICTIM: begin
              // The start shard is the hand modulo the live count, kept as residues.
              shard_nxt    = res_r[SHARD_W'(n_r - NUM_W'(1))];
              scan_cnt_nxt = '0;
              hand_nxt     = hand_r + HAND_W'(1);
              for (int k = 0; k < MAX_SHARDS; k++) begin
                if (hand_wrap || res_r[k] == SHARD_W'(k)) begin
                  res_nxt[k] = '0;
                end else begin
                  res_nxt[k] = res_r[k] + SHARD_W'(1);
                end
              end
              state_nxt = ST_SCAN;
            end
            OP_PIN, OP_UNPIN: begin
              if (int'(in_fid) >= MAX_FRAMES) begin
                bad_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                frame_nxt = FRAME_W'(in_fid);
                mod_start = 1'b1;
                state_nxt = ST_MOD;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          shard_nxt = mod_rem;
          state_nxt = ST_APPLY;
        end
      end

      ST_SCAN: begin
        if (occ_r[shard_r] != '0) begin
          found_nxt = 1'b1;
          frame_nxt = oldest_r[shard_r];
          state_nxt = ST_APPLY;
        end else if (NUM_W'(scan_cnt_r) == n_r - NUM_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + SHARD_W'(1);
          shard_nxt    = (scan_inc == n_r) ? '0 : SHARD_W'(scan_inc);
        end
      end

      ST_APPLY: begin
        state_nxt = ST_DONE;
        if (op_r == OP_VICTIM || (op_r == OP_PIN && tracked_r[frame_r])) begin
          if (occ_r[shard_r] <= CNT_W'(1)) begin
            occ_nxt[shard_r]     = '0;
            tracked_nxt[frame_r] = 1'b0;
            if (total_r != '0) begin
              total_nxt = total_r - CNT_W'(1);
            end
          end else begin
            // Neighbors of the frame are needed; fetch both links first.
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = frame_r;
            state_nxt        = ST_UNLINK;
          end
        end else if (op_r == OP_UNPIN && !tracked_r[frame_r]) begin
          if (occ_r[shard_r] == '0) begin
            oldest_nxt[shard_r] = frame_r;
          end else begin
            link_req.newer_wr_en   = 1'b1;
            link_req.newer_wr_addr = head;
            link_req.newer_wr_data = frame_r;
            link_req.older_wr_en   = 1'b1;
            link_req.older_wr_addr = frame_r;
            link_req.older_wr_data = head;
          end
          newest_nxt[shard_r]  = frame_r;
          occ_nxt[shard_r]     = occ_r[shard_r] + CNT_W'(1);
          tracked_nxt[frame_r] = 1'b1;
          total_nxt            = total_r + CNT_W'(1);
        end
      end

      ST_UNLINK: begin
        if (newest_r[shard_r] == frame_r) begin
          newest_nxt[shard_r] = od;
        end else begin
          link_req.older_wr_en   = 1'b1;
          link_req.older_wr_addr = nw;
          link_req.older_wr_data = od;
        end
        if (oldest_r[shard_r] == frame_r) begin
          oldest_nxt[shard_r] = nw;
        end else begin
          link_req.newer_wr_en   = 1'b1;
          link_req.newer_wr_addr = od;
          link_req.newer_wr_data = nw;
        end
        occ_nxt[shard_r]     = occ_r[shard_r] - CNT_W'(1);
        tracked_nxt[frame_r] = 1'b0;
        if (total_r != '0) begin
          total_nxt = total_r - CNT_W'(1);
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, bad_r, CNT_OUT_W'(total_r),
                           found_r ? FID_W'(frame_r) : FID_W'(0), found_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    newest_r   <= newest_nxt;
    oldest_r   <= oldest_nxt;
    op_r       <= op_nxt;
    frame_r    <= frame_nxt;
    shard_r    <= shard_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    found_r    <= found_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= NUM_W'(1);
      tracked_r   <= '0;
      total_r     <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_SHARDS; k++) begin
        occ_r[k] <= '0;
        res_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      tracked_r   <= tracked_nxt;
      total_r     <= total_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
      occ_r       <= occ_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

`default_nettype wire
